// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the framebuffer refresh block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/pfdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfdr_pkg
// Types, constants and helpers of the framebuffer dirty-page refresh block.
// ----------------------------------------------------------------------------
package pfdr_pkg;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int CHUNK_BYTES = 32;
    localparam int ROWS        = PAGES * 8;
    localparam int STORE_DEPTH = PAGES * COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(COLUMNS);

    localparam logic [7:0] ALL_PAGES    = 8'((1 << PAGES) - 1);
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] CTRL_CMD     = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] DEV_ADDR_RST = 8'h78;

    typedef enum logic [2:0] {
        ACT_SET_PIXEL    = 3'd0,
        ACT_CLEAR_PIXEL  = 3'd1,
        ACT_WRITE_BYTE   = 3'd2,
        ACT_CLEAR_AREA   = 3'd3,
        ACT_CLEAR_ALL    = 3'd4,
        ACT_FULL_REFRESH = 3'd5,
        ACT_REFRESH_STEP = 3'd6
    } t_action;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RMW_RD,
        S_RMW_WR,
        S_AREA_RD,
        S_AREA_WR,
        S_WIPE,
        S_STEP_PLAN,
        S_HDR,
        S_DATA_RD,
        S_DATA_EMIT,
        S_STEP_END,
        S_STATUS
    } t_state;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_STATUS,
        EMIT_HDR,
        EMIT_DATA
    } t_emit;

    typedef struct packed {
        logic  latch;
        logic  setup_rmw;
        logic  area_init;
        logic  area_mask;
        logic  area_adv;
        logic  rd;
        logic  rd_step;
        logic  rmw_wr;
        logic  sweep_wr;
        logic  full_ref;
        logic  step_begin;
        logic  step_plan;
        logic  step_end;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    rmw_ok;
        logic    area_ok;
        logic    step_ok;
        logic    area_last;
        logic    sweep_last;
        logic    hdr_last;
        logic    data_last;
        logic    out_free;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [2:0] pg,
                                                     input logic [COL_W-1:0] col);
        int a;
        a = int'(pg) * COLUMNS + int'(col);
        return ADDR_W'(a);
    endfunction

endpackage

// ===== design/pfdr_ram.sv =====
// ----------------------------------------------------------------------------
// pfdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pfdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfdr_ctrl
// Sequencer of the refresh block: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module pfdr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pfdr_pkg::t_dp_stat i_stat,
    output pfdr_pkg::t_dp_cmd  o_cmd
);

    pfdr_pkg::t_state r_state;
    pfdr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfdr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = pfdr_pkg::EMIT_NONE;
        unique case (r_state)
            pfdr_pkg::S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = pfdr_pkg::S_IDLE;
                end
            end
            pfdr_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = pfdr_pkg::S_DISPATCH;
                end
            end
            pfdr_pkg::S_DISPATCH: begin
                unique case (i_stat.action)
                    pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::ACT_CLEAR_PIXEL,
                    pfdr_pkg::ACT_WRITE_BYTE: begin
                        if (i_stat.rmw_ok) begin
                            o_cmd.setup_rmw = 1'b1;
                            n_state = pfdr_pkg::S_RMW_RD;
                        end else begin
                            n_state = pfdr_pkg::S_STATUS;
                        end
                    end
                    pfdr_pkg::ACT_CLEAR_AREA: begin
                        if (i_stat.area_ok) begin
                            o_cmd.area_init = 1'b1;
                            n_state = pfdr_pkg::S_AREA_RD;
                        end else begin
                            n_state = pfdr_pkg::S_STATUS;
                        end
                    end
                    pfdr_pkg::ACT_CLEAR_ALL: begin
                        n_state = pfdr_pkg::S_WIPE;
                    end
                    pfdr_pkg::ACT_FULL_REFRESH: begin
                        o_cmd.full_ref = 1'b1;
                        n_state = pfdr_pkg::S_STATUS;
                    end
                    pfdr_pkg::ACT_REFRESH_STEP: begin
                        if (i_stat.step_ok) begin
                            o_cmd.step_begin = 1'b1;
                            n_state = pfdr_pkg::S_STEP_PLAN;
                        end else begin
                            n_state = pfdr_pkg::S_STATUS;
                        end
                    end
                    default: begin
                        n_state = pfdr_pkg::S_STATUS;
                    end
                endcase
            end
            pfdr_pkg::S_RMW_RD: begin
                o_cmd.rd = 1'b1;
                n_state = pfdr_pkg::S_RMW_WR;
            end
            pfdr_pkg::S_RMW_WR: begin
                o_cmd.rmw_wr = 1'b1;
                n_state = pfdr_pkg::S_STATUS;
            end
            pfdr_pkg::S_AREA_RD: begin
                o_cmd.rd = 1'b1;
                o_cmd.area_mask = 1'b1;
                n_state = pfdr_pkg::S_AREA_WR;
            end
            pfdr_pkg::S_AREA_WR: begin
                o_cmd.rmw_wr = 1'b1;
                o_cmd.area_adv = 1'b1;
                n_state = i_stat.area_last ? pfdr_pkg::S_STATUS : pfdr_pkg::S_AREA_RD;
            end
            pfdr_pkg::S_WIPE: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.full_ref = 1'b1;
                    n_state = pfdr_pkg::S_STATUS;
                end
            end
            pfdr_pkg::S_STEP_PLAN: begin
                o_cmd.step_plan = 1'b1;
                n_state = pfdr_pkg::S_HDR;
            end
            pfdr_pkg::S_HDR: begin
                o_cmd.emit = pfdr_pkg::EMIT_HDR;
                if (i_stat.out_free && i_stat.hdr_last) begin
                    n_state = pfdr_pkg::S_DATA_RD;
                end
            end
            pfdr_pkg::S_DATA_RD: begin
                o_cmd.rd = 1'b1;
                o_cmd.rd_step = 1'b1;
                n_state = pfdr_pkg::S_DATA_EMIT;
            end
            pfdr_pkg::S_DATA_EMIT: begin
                o_cmd.emit = pfdr_pkg::EMIT_DATA;
                if (i_stat.out_free) begin
                    n_state = i_stat.data_last ? pfdr_pkg::S_STEP_END
                                               : pfdr_pkg::S_DATA_RD;
                end
            end
            pfdr_pkg::S_STEP_END: begin
                o_cmd.step_end = 1'b1;
                n_state = pfdr_pkg::S_IDLE;
            end
            pfdr_pkg::S_STATUS: begin
                o_cmd.emit = pfdr_pkg::EMIT_STATUS;
                if (i_stat.out_free) begin
                    n_state = pfdr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfdr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != pfdr_pkg::S_IDLE);

endmodule

// ===== design/pfdr_dp.sv =====
// ----------------------------------------------------------------------------
// pfdr_dp
// Datapath: frame store, dirty tracking, refresh cursor and output register.
// ----------------------------------------------------------------------------
module pfdr_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfdr_pkg::t_dp_cmd  i_cmd,
    output pfdr_pkg::t_dp_stat o_stat,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_x,
    input  logic [7:0]         i_y,
    input  logic [7:0]         i_width,
    input  logic [7:0]         i_height,
    input  logic [2:0]         i_page,
    input  logic [7:0]         i_value,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_tx_start,
    output logic               o_tx_stop,
    output logic               o_is_last,
    output logic               o_more_pending
);

    localparam int AW = pfdr_pkg::ADDR_W;
    localparam int CW = pfdr_pkg::COL_W;

    pfdr_pkg::t_action r_action;
    logic [7:0]    r_x, r_y, r_w, r_h, r_value;
    logic [2:0]    r_page_in;
    logic [2:0]    r_pg, r_pg_last;
    logic [CW-1:0] r_col, r_xs;
    logic [8:0]    r_xe, r_ye;
    logic [7:0]    r_set_m, r_clr_m;
    logic [7:0]    r_dirty;
    logic          r_busy, r_rw;
    logic [2:0]    r_cur_page;
    logic [6:0]    r_off;
    logic [5:0]    r_cnt, r_i;
    logic          r_final, r_pend;
    logic [2:0]    r_idx;
    logic [AW-1:0] r_sweep;
    logic [7:0]    r_dev;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_obv, r_ostart, r_ostop, r_olast, r_opend;

    logic          out_free;
    logic [7:0]    rdata, new_byte, pix_m, area_m, hdr_byte;
    logic [2:0]    lo_bit, hi_bit;
    logic [8:0]    xe_raw, ye_raw, xe_c, ye_c, ye_m1, ye_r_m1;
    logic [2:0]    low_dirty;
    logic [7:0]    rem, off_col;
    logic [8:0]    nxt_off;
    logic [7:0]    clr_bit, dirty_after;
    logic          we, re, changed;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;

    pfdr_ram #(
        .WIDTH(8),
        .DEPTH(pfdr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign out_free = !r_ovalid || !i_stall;
    assign pix_m    = 8'(1) << r_y[2:0];
    assign new_byte = (rdata & ~r_clr_m) | r_set_m;
    assign changed  = (new_byte != rdata);

    assign xe_raw = {1'b0, r_x} + {1'b0, r_w};
    assign ye_raw = {1'b0, r_y} + {1'b0, r_h};
    assign xe_c   = (xe_raw > 9'(pfdr_pkg::COLUMNS)) ? 9'(pfdr_pkg::COLUMNS) : xe_raw;
    assign ye_c   = (ye_raw > 9'(pfdr_pkg::ROWS)) ? 9'(pfdr_pkg::ROWS) : ye_raw;
    assign ye_m1  = ye_c - 9'd1;
    assign ye_r_m1 = r_ye - 9'd1;

    assign lo_bit = (r_pg == 3'(r_y >> 3)) ? r_y[2:0] : 3'd0;
    assign hi_bit = (r_pg == r_pg_last) ? ye_r_m1[2:0] : 3'd7;
    assign area_m = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));

    always_comb begin
        low_dirty = 3'd0;
        for (int p = pfdr_pkg::PAGES - 1; p >= 0; p--) begin
            if (r_dirty[p]) begin
                low_dirty = 3'(p);
            end
        end
    end

    assign rem         = 8'(pfdr_pkg::COLUMNS) - {1'b0, r_off};
    assign nxt_off     = {2'b00, r_off} + 9'(pfdr_pkg::CHUNK_BYTES);
    assign clr_bit     = r_rw ? 8'h00 : (8'(1) << r_cur_page);
    assign dirty_after = r_dirty & ~clr_bit;
    assign off_col     = {1'b0, r_off} + {2'b00, r_i};

    always_comb begin
        unique case (r_idx)
            3'd0:    hdr_byte = r_dev;
            3'd1:    hdr_byte = pfdr_pkg::CTRL_CMD;
            3'd2:    hdr_byte = pfdr_pkg::CMD_PAGE | {5'd0, r_cur_page};
            3'd3:    hdr_byte = pfdr_pkg::CMD_COL_HI | {5'd0, r_off[6:4]};
            3'd4:    hdr_byte = {4'd0, r_off[3:0]};
            3'd5:    hdr_byte = r_dev;
            default: hdr_byte = pfdr_pkg::CTRL_DATA;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = pfdr_pkg::store_addr(r_pg, r_col);
        wdata = new_byte;
        if (i_cmd.sweep_wr) begin
            we    = 1'b1;
            waddr = r_sweep;
            wdata = 8'h00;
        end else if (i_cmd.rmw_wr && changed) begin
            we = 1'b1;
        end
    end

    assign re    = i_cmd.rd;
    assign raddr = i_cmd.rd_step ? pfdr_pkg::store_addr(r_cur_page, CW'(off_col))
                                 : pfdr_pkg::store_addr(r_pg, r_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action  <= pfdr_pkg::t_action'(i_action);
            r_x       <= i_x;
            r_y       <= i_y;
            r_w       <= i_width;
            r_h       <= i_height;
            r_page_in <= i_page;
            r_value   <= i_value;
        end
        if (i_cmd.setup_rmw) begin
            r_col <= CW'(r_x);
            if (r_action == pfdr_pkg::ACT_WRITE_BYTE) begin
                r_pg    <= r_page_in;
                r_clr_m <= 8'hFF;
                r_set_m <= r_value;
            end else if (r_action == pfdr_pkg::ACT_SET_PIXEL) begin
                r_pg    <= 3'(r_y >> 3);
                r_clr_m <= 8'h00;
                r_set_m <= pix_m;
            end else begin
                r_pg    <= 3'(r_y >> 3);
                r_clr_m <= pix_m;
                r_set_m <= 8'h00;
            end
        end
        if (i_cmd.area_init) begin
            r_pg      <= 3'(r_y >> 3);
            r_col     <= CW'(r_x);
            r_xs      <= CW'(r_x);
            r_xe      <= xe_c;
            r_ye      <= ye_c;
            r_pg_last <= 3'(ye_m1 >> 3);
        end
        if (i_cmd.area_mask) begin
            r_clr_m <= area_m;
            r_set_m <= 8'h00;
        end
        if (i_cmd.area_adv) begin
            if ({1'b0, r_col} + 9'd1 == r_xe) begin
                r_col <= r_xs;
                r_pg  <= r_pg + 3'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
        if (i_cmd.step_plan) begin
            r_cnt   <= (rem < 8'(pfdr_pkg::CHUNK_BYTES)) ? 6'(rem)
                                                         : 6'(pfdr_pkg::CHUNK_BYTES);
            r_final <= (nxt_off >= 9'(pfdr_pkg::COLUMNS));
            r_pend  <= (nxt_off < 9'(pfdr_pkg::COLUMNS)) || (dirty_after != 8'h00);
        end
        if (out_free) begin
            unique case (i_cmd.emit)
                pfdr_pkg::EMIT_STATUS: begin
                    r_obyte  <= 8'h00;
                    r_obv    <= 1'b0;
                    r_ostart <= 1'b0;
                    r_ostop  <= 1'b0;
                    r_olast  <= 1'b1;
                    r_opend  <= (r_dirty != 8'h00) || r_busy;
                end
                pfdr_pkg::EMIT_HDR: begin
                    r_obyte  <= hdr_byte;
                    r_obv    <= 1'b1;
                    r_ostart <= (r_idx == 3'd0) || (r_idx == 3'd5);
                    r_ostop  <= (r_idx == 3'd4);
                    r_olast  <= 1'b0;
                    r_opend  <= r_pend;
                end
                pfdr_pkg::EMIT_DATA: begin
                    r_obyte  <= rdata;
                    r_obv    <= 1'b1;
                    r_ostart <= 1'b0;
                    r_ostop  <= (r_i + 6'd1 == r_cnt);
                    r_olast  <= (r_i + 6'd1 == r_cnt);
                    r_opend  <= r_pend;
                end
                default: begin
                    r_obyte <= r_obyte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty    <= 8'h00;
            r_busy     <= 1'b0;
            r_rw       <= 1'b0;
            r_cur_page <= 3'd0;
            r_off      <= 7'd0;
            r_sweep    <= '0;
            r_dev      <= pfdr_pkg::DEV_ADDR_RST;
            r_ovalid   <= 1'b0;
            r_idx      <= 3'd0;
            r_i        <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                r_dev <= i_cfg_data;
            end
            if (i_cmd.sweep_wr) begin
                r_sweep <= (r_sweep == AW'(pfdr_pkg::STORE_DEPTH - 1)) ? '0
                                                                       : r_sweep + AW'(1);
            end
            if (i_cmd.rmw_wr && changed) begin
                r_dirty[r_pg] <= 1'b1;
                if (r_busy && r_cur_page == r_pg) begin
                    r_rw <= 1'b1;
                end
            end
            if (i_cmd.full_ref) begin
                r_dirty <= pfdr_pkg::ALL_PAGES;
                if (r_busy) begin
                    r_rw <= 1'b1;
                end
            end
            if (i_cmd.step_begin && !r_busy) begin
                r_cur_page <= low_dirty;
                r_off      <= 7'd0;
                r_busy     <= 1'b1;
                r_rw       <= 1'b0;
            end
            if (i_cmd.step_plan) begin
                r_idx <= 3'd0;
                r_i   <= 6'd0;
            end
            if (out_free && i_cmd.emit == pfdr_pkg::EMIT_HDR) begin
                r_idx <= r_idx + 3'd1;
            end
            if (out_free && i_cmd.emit == pfdr_pkg::EMIT_DATA) begin
                r_i <= r_i + 6'd1;
            end
            if (i_cmd.step_end) begin
                if (r_final) begin
                    r_dirty <= dirty_after;
                    r_busy  <= 1'b0;
                    r_off   <= 7'd0;
                end else begin
                    r_off <= 7'(nxt_off);
                end
            end
            if (out_free) begin
                r_ovalid <= (i_cmd.emit != pfdr_pkg::EMIT_NONE);
            end
        end
    end

    assign o_stat.action     = r_action;
    assign o_stat.rmw_ok     = (r_action == pfdr_pkg::ACT_WRITE_BYTE)
        ? ({1'b0, r_x} < 9'(pfdr_pkg::COLUMNS) && {1'b0, r_page_in} < 4'(pfdr_pkg::PAGES))
        : ({1'b0, r_x} < 9'(pfdr_pkg::COLUMNS) && {1'b0, r_y} < 9'(pfdr_pkg::ROWS));
    assign o_stat.area_ok    = (r_w != 8'd0) && (r_h != 8'd0)
        && ({1'b0, r_x} < 9'(pfdr_pkg::COLUMNS)) && ({1'b0, r_y} < 9'(pfdr_pkg::ROWS));
    assign o_stat.step_ok    = r_busy || (r_dirty != 8'h00);
    assign o_stat.area_last  = ({1'b0, r_col} + 9'd1 == r_xe) && (r_pg == r_pg_last);
    assign o_stat.sweep_last = (r_sweep == AW'(pfdr_pkg::STORE_DEPTH - 1));
    assign o_stat.hdr_last   = (r_idx == 3'd6);
    assign o_stat.data_last  = (r_i + 6'd1 == r_cnt);
    assign o_stat.out_free   = out_free;

    assign o_valid        = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_byte_valid   = r_obv;
    assign o_tx_start     = r_ostart;
    assign o_tx_stop      = r_ostop;
    assign o_is_last      = r_olast;
    assign o_more_pending = r_opend;

endmodule

// ===== design/page_framebuffer_dirty_refresh_top.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_refresh_top
// Page-organized monochrome frame store with dirty-page chunked refresh.
// ----------------------------------------------------------------------------
// One item is handled at a time; store accesses use the write and read ports
// of the frame RAM. A pixel or byte write reads the byte and writes it back,
// a clear-area does so for each touched byte, and clear-all sweeps zeros
// through all 1024 bytes of the store. A refresh step sends seven header
// bytes, then reads and sends each byte of its chunk, holding while the
// output is stalled. After reset the block clears the store before it takes
// its first item; configuration writes are taken at any time.
module page_framebuffer_dirty_refresh_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_action,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic [7:0] i_width,
    input  logic [7:0] i_height,
    input  logic [2:0] i_page,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_tx_start,
    output logic       o_tx_stop,
    output logic       o_is_last,
    output logic       o_more_pending,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

`include "assert_macros.svh"

    pfdr_pkg::t_dp_cmd  cmd;
    pfdr_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pfdr_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    pfdr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_width       (i_width),
        .i_height      (i_height),
        .i_page        (i_page),
        .i_value       (i_value),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_tx_start    (o_tx_start),
        .o_tx_stop     (o_tx_stop),
        .o_is_last     (o_is_last),
        .o_more_pending(o_more_pending)
    );

    `ASSERT_IMPLIES(a_start_is_byte, i_clk, i_rst_n, o_valid && o_tx_start, o_byte_valid, "start mark on a status result")
    `ASSERT_IMPLIES(a_status_last, i_clk, i_rst_n, o_valid && !o_byte_valid, o_is_last && !o_tx_start && !o_tx_stop, "status result malformed")
    `ASSERT_IMPLIES(a_busy_stall, i_clk, i_rst_n, o_valid && !o_is_last, o_stall, "input taken during a refresh step")

endmodule

// ===== test/pfdr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdr_checker
// Watches the input, configuration and result channels of the framebuffer
// refresh block, predicts every result from its own copy of the block state
// and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module pfdr_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_in_stall,
    input  logic [2:0] i_action,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic [7:0] i_width,
    input  logic [7:0] i_height,
    input  logic [2:0] i_page,
    input  logic [7:0] i_value,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_byte_valid,
    input  logic       i_tx_start,
    input  logic       i_tx_stop,
    input  logic       i_is_last,
    input  logic       i_more_pending,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    localparam int COLUMNS     = pfdr_pkg::COLUMNS;
    localparam int ROWS        = pfdr_pkg::ROWS;
    localparam int PAGES       = pfdr_pkg::PAGES;
    localparam int CHUNK_BYTES = pfdr_pkg::CHUNK_BYTES;
    localparam int STORE_DEPTH = pfdr_pkg::STORE_DEPTH;

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       start;
        logic       stop;
        logic       last;
        logic       pend;
    } t_bus_word;

    logic [7:0] frame [STORE_DEPTH];
    logic [7:0] dirty;
    logic       busy;
    logic [2:0] cur_page;
    int         offset;
    logic       rewritten;
    logic [7:0] dev_addr;
    t_bus_word  bus_q[$];
    t_bus_word  step_q[$];
    int         errors;

    assign o_errors  = errors;
    assign o_pending = bus_q.size();

    function automatic t_bus_word word(logic [7:0] d, logic s, logic p);
        t_bus_word w;
        w = '0;
        w.data = d;
        w.bvalid = 1'b1;
        w.start = s;
        w.stop = p;
        return w;
    endfunction

    task automatic write_store(int pg, int col, logic [7:0] v);
        if (frame[pg * COLUMNS + col] != v) begin
            frame[pg * COLUMNS + col] = v;
            dirty[pg] = 1'b1;
            if (busy && cur_page == pg) rewritten = 1'b1;
        end
    endtask

    task automatic predict_item(pfdr_pkg::t_action act, int x, int y, int w, int h,
                                int pg, logic [7:0] v);
        int xe;
        int ye;
        logic [7:0] m;
        logic pend;
        int cnt;
        step_q.delete();
        case (act)
            pfdr_pkg::ACT_SET_PIXEL, pfdr_pkg::ACT_CLEAR_PIXEL: begin
                if (x < COLUMNS && y < ROWS) begin
                    m = 8'(1 << (y % 8));
                    if (act == pfdr_pkg::ACT_SET_PIXEL)
                        write_store(y / 8, x, frame[(y / 8) * COLUMNS + x] | m);
                    else
                        write_store(y / 8, x, frame[(y / 8) * COLUMNS + x] & ~m);
                end
            end
            pfdr_pkg::ACT_WRITE_BYTE: begin
                if (x < COLUMNS && pg < PAGES) write_store(pg, x, v);
            end
            pfdr_pkg::ACT_CLEAR_AREA: begin
                if (w != 0 && h != 0 && x < COLUMNS && y < ROWS) begin
                    xe = (x + w > COLUMNS) ? COLUMNS : x + w;
                    ye = (y + h > ROWS) ? ROWS : y + h;
                    for (int p = y / 8; p <= (ye - 1) / 8; p++) begin
                        m = '0;
                        for (int b = 0; b < 8; b++)
                            if (p * 8 + b >= y && p * 8 + b < ye) m[b] = 1'b1;
                        for (int c = x; c < xe; c++)
                            write_store(p, c, frame[p * COLUMNS + c] & ~m);
                    end
                end
            end
            pfdr_pkg::ACT_CLEAR_ALL, pfdr_pkg::ACT_FULL_REFRESH: begin
                if (act == pfdr_pkg::ACT_CLEAR_ALL)
                    for (int i = 0; i < STORE_DEPTH; i++) frame[i] = '0;
                dirty = pfdr_pkg::ALL_PAGES;
                if (busy) rewritten = 1'b1;
            end
            pfdr_pkg::ACT_REFRESH_STEP: begin
                if (busy || dirty != 0) begin
                    if (!busy) begin
                        for (int p = PAGES - 1; p >= 0; p--)
                            if (dirty[p]) cur_page = 3'(p);
                        offset = 0;
                        busy = 1'b1;
                        rewritten = 1'b0;
                    end
                    step_q.push_back(word(dev_addr, 1'b1, 1'b0));
                    step_q.push_back(word(pfdr_pkg::CTRL_CMD, 1'b0, 1'b0));
                    step_q.push_back(word(pfdr_pkg::CMD_PAGE | 8'(cur_page), 1'b0, 1'b0));
                    step_q.push_back(word(pfdr_pkg::CMD_COL_HI | 8'(offset >> 4), 1'b0,
                                          1'b0));
                    step_q.push_back(word(8'(offset & 15), 1'b0, 1'b1));
                    cnt = (offset + CHUNK_BYTES > COLUMNS) ? COLUMNS - offset
                                                           : CHUNK_BYTES;
                    step_q.push_back(word(dev_addr, 1'b1, 1'b0));
                    step_q.push_back(word(pfdr_pkg::CTRL_DATA, 1'b0, cnt == 0));
                    for (int i = 0; i < cnt; i++)
                        step_q.push_back(word(frame[int'(cur_page) * COLUMNS
                                                    + offset + i], 1'b0, i + 1 == cnt));
                    if (offset + CHUNK_BYTES >= COLUMNS) begin
                        if (!rewritten) dirty[cur_page] = 1'b0;
                        busy = 1'b0;
                        offset = 0;
                    end else begin
                        offset = offset + CHUNK_BYTES;
                    end
                end
            end
            default: ;
        endcase
        if (step_q.size() == 0) step_q.push_back('0);
        pend = (dirty != 0) || busy;
        foreach (step_q[i]) step_q[i].pend = pend;
        step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) bus_q.push_back(step_q[i]);
    endtask

    always @(posedge i_clk) begin
        t_bus_word got;
        t_bus_word exp;
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) frame[i] = '0;
            dirty = '0;
            busy = 1'b0;
            cur_page = '0;
            offset = 0;
            rewritten = 1'b0;
            dev_addr = pfdr_pkg::DEV_ADDR_RST;
            bus_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) dev_addr = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_byte, i_byte_valid, i_tx_start, i_tx_stop, i_is_last,
                       i_more_pending};
                if (bus_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result transfer: %p", got);
                end else begin
                    exp = bus_q.pop_front();
                    if (got != exp) begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %p, actual %p", exp, got);
                    end
                end
            end
            if (i_valid && !i_in_stall)
                predict_item(pfdr_pkg::t_action'(i_action), i_x, i_y, i_width, i_height,
                             i_page, i_value);
        end
    end

endmodule

// ===== test/tb_page_framebuffer_dirty_refresh_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_framebuffer_dirty_refresh_top
// Drives pixel, byte, area, clear and refresh items with random idling into
// the framebuffer refresh block, changes the device address between phases,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_dirty_refresh_top;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] action;
    logic [7:0] x, y, wd, ht, val;
    logic [2:0] page;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid, tx_start, tx_stop, is_last, more_pending;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;
    int         cycles;
    bit         calm;

    page_framebuffer_dirty_refresh_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_action(action), .i_x(x), .i_y(y), .i_width(wd), .i_height(ht),
        .i_page(page), .i_value(val),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_byte(out_byte), .o_byte_valid(byte_valid), .o_tx_start(tx_start),
        .o_tx_stop(tx_stop), .o_is_last(is_last), .o_more_pending(more_pending),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    pfdr_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_action(action), .i_x(x), .i_y(y), .i_width(wd), .i_height(ht),
        .i_page(page), .i_value(val),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_byte(out_byte), .i_byte_valid(byte_valid), .i_tx_start(tx_start),
        .i_tx_stop(tx_stop), .i_is_last(is_last), .i_more_pending(more_pending),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("** page_framebuffer_dirty_refresh_top: FAILED **");
            $finish;
        end
    end

    // The receiver stalls in random bursts until the calm part of the run.
    always @(posedge clk) begin
        int burst;
        if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 13);
            out_stall <= 1'b1;
            repeat (burst) @(posedge clk);
        end
        out_stall <= 1'b0;
    end

    task automatic send(pfdr_pkg::t_action a, int xi, int yi, int wi, int hi, int pi,
                        int vi);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        x <= 8'(xi);
        y <= 8'(yi);
        wd <= 8'(wi);
        ht <= 8'(hi);
        page <= 3'(pi);
        val <= 8'(vi);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic set_address(logic [7:0] a);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= a;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            send(pfdr_pkg::t_action'($urandom_range(0, 1)), $urandom_range(0, 140),
                 $urandom_range(0, 70), $urandom, $urandom, $urandom, $urandom);
        else if (r < 45)
            send(pfdr_pkg::ACT_WRITE_BYTE, $urandom_range(0, 140), $urandom, $urandom,
                 $urandom, $urandom, $urandom);
        else if (r < 52)
            send(pfdr_pkg::ACT_CLEAR_AREA, $urandom_range(0, 130), $urandom_range(0, 66),
                 $urandom_range(0, 40), $urandom_range(0, 20), $urandom, $urandom);
        else if (r < 54)
            send(pfdr_pkg::ACT_CLEAR_AREA, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        else if (r < 56)
            send(pfdr_pkg::ACT_CLEAR_ALL, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        else if (r < 59)
            send(pfdr_pkg::ACT_FULL_REFRESH, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        else if (r < 60)
            send(pfdr_pkg::t_action'(3'd7), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        else
            send(pfdr_pkg::ACT_REFRESH_STEP, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    endtask

    initial begin
        cycles = 0;
        calm = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        action <= pfdr_pkg::ACT_SET_PIXEL;
        x <= '0;
        y <= '0;
        wd <= '0;
        ht <= '0;
        page <= '0;
        val <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send(pfdr_pkg::ACT_REFRESH_STEP, 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_SET_PIXEL, 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_SET_PIXEL, 127, 63, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_SET_PIXEL, 128, 5, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_SET_PIXEL, 5, 64, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_SET_PIXEL, 255, 255, 255, 255, 7, 255);
        send(pfdr_pkg::ACT_CLEAR_PIXEL, 127, 63, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_WRITE_BYTE, 10, 0, 0, 0, 7, 8'hFF);
        send(pfdr_pkg::ACT_WRITE_BYTE, 128, 0, 0, 0, 3, 8'hAA);
        send(pfdr_pkg::ACT_WRITE_BYTE, 10, 0, 0, 0, 7, 8'hFF);
        send(pfdr_pkg::ACT_REFRESH_STEP, 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_WRITE_BYTE, 40, 0, 0, 0, 0, 8'h55);
        repeat (4) send(pfdr_pkg::ACT_REFRESH_STEP, 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_CLEAR_AREA, 0, 0, 0, 5, 0, 0);
        send(pfdr_pkg::ACT_CLEAR_AREA, 0, 0, 5, 0, 0, 0);
        send(pfdr_pkg::ACT_CLEAR_AREA, 128, 0, 5, 5, 0, 0);
        send(pfdr_pkg::ACT_CLEAR_AREA, 120, 60, 255, 255, 0, 0);
        send(pfdr_pkg::ACT_CLEAR_AREA, 0, 3, 200, 10, 0, 0);
        send(pfdr_pkg::ACT_FULL_REFRESH, 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_CLEAR_ALL, 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::t_action'(3'd7), 0, 0, 0, 0, 0, 0);
        send(pfdr_pkg::ACT_REFRESH_STEP, 0, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            set_address(ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : 8'($urandom));
            for (int i = 0; i < 80; i++) begin
                if (ph == 3 && i == 60) calm = 1'b1;
                random_item();
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0) begin
            $display("** page_framebuffer_dirty_refresh_top: PASSED **");
        end else begin
            $display("** page_framebuffer_dirty_refresh_top: FAILED **");
        end
        $finish;
    end

endmodule
